>>> src/mkte_pkg.sv
// Shared types, codes and the letter table of the multi-tap keypad text entry block.
// No dependencies; every other file of the block refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package mkte_pkg;

  localparam int LineLengthDefault = 32;
  localparam int NumKeys           = 9;
  localparam int PressW            = 14;

  localparam logic [7:0]        SpaceCode = 8'h20;
  localparam logic [7:0]        DigitZero = 8'h30;
  localparam logic [1:0]        NoTap     = 2'd3;
  localparam logic [PressW-1:0] PressWrap = 14'd10000;

  // Key pairs that act as commands
  localparam logic [NumKeys-1:0] KeysClear = 9'h006;
  localparam logic [NumKeys-1:0] KeysMode  = 9'h030;
  localparam logic [NumKeys-1:0] KeysSpace = 9'h180;

  typedef logic [3:0] key_idx_t;
  typedef logic [1:0] tap_t;

  // Operation on the character cells for one accepted key transaction
  typedef struct packed {
    logic       clear;
    logic       shift;
    logic       write;
    logic [7:0] ch;
  } line_op_t;

  // Operation on the output shift chain
  typedef struct packed {
    logic load;
    logic advance;
  } out_op_t;

  function automatic logic [7:0] letter(input key_idx_t k, input tap_t t);
    logic [23:0] row;
    case (k)
      4'd0:    row = {"Z", "Q", "."};
      4'd1:    row = {"C", "B", "A"};
      4'd2:    row = {"F", "E", "D"};
      4'd3:    row = {"I", "H", "G"};
      4'd4:    row = {"L", "K", "J"};
      4'd5:    row = {"O", "N", "M"};
      4'd6:    row = {"S", "R", "P"};
      4'd7:    row = {"V", "U", "T"};
      4'd8:    row = {"Y", "X", "W"};
      default: row = {SpaceCode, SpaceCode, SpaceCode};
    endcase
    case (t)
      2'd0:    letter = row[7:0];
      2'd1:    letter = row[15:8];
      default: letter = row[23:16];
    endcase
  endfunction

endpackage

`default_nettype wire

>>> src/mkte_in_if.sv
// Input channel of the keypad text entry block: valid/ready handshake and the key vector.
// Depends on mkte_pkg for the key count.
`timescale 1ns / 1ps
`default_nettype none

interface mkte_in_if;
  logic                          valid;
  logic                          ready;
  logic [mkte_pkg::NumKeys-1:0]  keys_pressed;

  modport source (output valid, output keys_pressed, input ready);
  modport sink   (input valid, input keys_pressed, output ready);
endinterface

`default_nettype wire

>>> src/mkte_out_if.sv
// Output channel of the keypad text entry block: valid/ready handshake and one display column.
// Depends on mkte_pkg for the counter width.
`timescale 1ns / 1ps
`default_nettype none

interface mkte_out_if;
  logic                         valid;
  logic                         ready;
  logic [4:0]                   char_position;
  logic [7:0]                   char_code;
  logic                         digit_mode;
  logic [mkte_pkg::PressW-1:0]  press_count;
  logic                         last_char;

  modport source (output valid, output char_position, output char_code, output digit_mode,
                  output press_count, output last_char, input ready);
  modport sink   (input valid, input char_position, input char_code, input digit_mode,
                  input press_count, input last_char, output ready);
endinterface

`default_nettype wire

>>> src/mkte_cell.sv
// One column of the display line: the stored character and its slot in the output shift chain.
// Depends on mkte_pkg for the operation structs and the space code.
`timescale 1ns / 1ps
`default_nettype none

module mkte_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mkte_pkg::line_op_t op,
  input  wire logic               wr_en,
  input  wire logic [7:0]         right_ch,
  input  wire logic               visible,
  input  wire mkte_pkg::out_op_t  out_op,
  input  wire logic [7:0]         right_out,
  output logic [7:0]              ch,
  output logic [7:0]              out_ch
);

  // Stored character: clear, take the right neighbor on a shift, or take the new character
  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= mkte_pkg::SpaceCode;
    end else if (op.clear) begin
      ch <= mkte_pkg::SpaceCode;
    end else if (op.shift) begin
      ch <= right_ch;
    end else if (wr_en) begin
      ch <= op.ch;
    end
  end

  // Output slot: snapshot the column, then move toward column zero one step per transaction
  always_ff @(posedge clk) begin
    if (out_op.load) begin
      out_ch <= visible ? ch : mkte_pkg::SpaceCode;
    end else if (out_op.advance) begin
      out_ch <= right_out;
    end
  end

endmodule

`default_nettype wire

>>> src/mkte_ctrl.sv
// Key decoder and entry state: commands, multi-tap memory, mode, line length, press counter.
// Depends on mkte_pkg; drives the line operation for the row of mkte_cell columns.
`timescale 1ns / 1ps
`default_nettype none

module mkte_ctrl #(
  parameter int LINE_LENGTH = mkte_pkg::LineLengthDefault,
  parameter int IDX_W       = (LINE_LENGTH > 1) ? $clog2(LINE_LENGTH) : 1,
  parameter int LEN_W       = $clog2(LINE_LENGTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          fire,
  input  wire logic [mkte_pkg::NumKeys-1:0]  keys,
  output mkte_pkg::line_op_t                 op,
  output logic [IDX_W-1:0]                   wr_idx,
  output logic [LEN_W-1:0]                   line_len,
  output logic                               mode,
  output logic [mkte_pkg::PressW-1:0]        press_total
);

  localparam logic [LEN_W-1:0] FullLen = LEN_W'(LINE_LENGTH);

  logic                        first_tap;
  mkte_pkg::tap_t              tap [mkte_pkg::NumKeys];

  mkte_pkg::key_idx_t          top;
  mkte_pkg::key_idx_t          oth;
  logic                        any_key;
  logic                        found;
  logic [3:0]                  n_press;
  logic [mkte_pkg::PressW-1:0] press_sum;
  logic [mkte_pkg::PressW-1:0] press_next;
  logic                        is_clr, is_mode, is_space, is_key;
  logic                        do_append, append, rewrite, full;
  mkte_pkg::tap_t              tap_top, tap_step;
  logic [LEN_W-1:0]            len_m1;
  logic [7:0]                  new_ch;

  // Highest pressed key, press count, and the current tap slot of that key
  always_comb begin
    top     = '0;
    n_press = '0;
    tap_top = mkte_pkg::NoTap;
    for (int i = 0; i < mkte_pkg::NumKeys; i++) begin
      if (keys[i]) begin
        top     = mkte_pkg::key_idx_t'(i);
        n_press = n_press + 4'd1;
      end
    end
    for (int i = 0; i < mkte_pkg::NumKeys; i++) begin
      if (top == mkte_pkg::key_idx_t'(i)) tap_top = tap[i];
    end
  end

  // Lowest other key with a tap still recorded
  always_comb begin
    found = 1'b0;
    oth   = '0;
    for (int i = 0; i < mkte_pkg::NumKeys; i++) begin
      if (!found && top != mkte_pkg::key_idx_t'(i) && tap[i] != mkte_pkg::NoTap) begin
        found = 1'b1;
        oth   = mkte_pkg::key_idx_t'(i);
      end
    end
  end

  always_comb begin
    any_key   = |keys;
    press_sum = press_total + mkte_pkg::PressW'(n_press);
    press_next = (press_sum >= mkte_pkg::PressWrap) ? press_sum - mkte_pkg::PressWrap
                                                    : press_sum;
    is_clr   = (keys & mkte_pkg::KeysClear) == mkte_pkg::KeysClear;
    is_mode  = !is_clr && ((keys & mkte_pkg::KeysMode) == mkte_pkg::KeysMode);
    is_space = !is_clr && !is_mode && ((keys & mkte_pkg::KeysSpace) == mkte_pkg::KeysSpace);
    is_key   = !is_clr && !is_mode && !is_space && any_key;

    do_append = found || first_tap;
    tap_step  = (tap_top >= 2'd2) ? 2'd0 : tap_top + 2'd1;
    append    = is_space || (is_key && (mode || do_append));
    rewrite   = is_key && !mode && !do_append;
    full      = line_len == FullLen;
    len_m1    = line_len - LEN_W'(1);

    if (is_space) begin
      new_ch = mkte_pkg::SpaceCode;
    end else if (mode) begin
      new_ch = mkte_pkg::DigitZero + 8'(top) + 8'd1;
    end else if (do_append) begin
      new_ch = mkte_pkg::letter(top, 2'd0);
    end else begin
      new_ch = mkte_pkg::letter(top, tap_step);
    end

    op.clear = fire && is_clr;
    op.shift = fire && append && full;
    op.write = fire && ((append && !full) || (rewrite && line_len != '0));
    op.ch    = new_ch;
    wr_idx   = append ? line_len[IDX_W-1:0] : len_m1[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_len    <= '0;
      mode        <= 1'b0;
      first_tap   <= 1'b1;
      press_total <= '0;
      for (int i = 0; i < mkte_pkg::NumKeys; i++) tap[i] <= mkte_pkg::NoTap;
    end else if (fire) begin
      press_total <= press_next;
      if (is_clr) begin
        line_len <= '0;
      end
      if (is_mode) begin
        mode      <= !mode;
        first_tap <= 1'b1;
        for (int i = 0; i < mkte_pkg::NumKeys; i++) tap[i] <= mkte_pkg::NoTap;
      end
      if (append && !full) begin
        line_len <= line_len + LEN_W'(1);
      end
      if (is_key && !mode) begin
        first_tap <= 1'b0;
        for (int i = 0; i < mkte_pkg::NumKeys; i++) begin
          if (found && oth == mkte_pkg::key_idx_t'(i)) begin
            tap[i] <= mkte_pkg::NoTap;
          end
          if (top == mkte_pkg::key_idx_t'(i)) begin
            tap[i] <= do_append ? 2'd0 : tap_step;
          end
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_press_range: assert property (@(posedge clk) disable iff (rst)
    press_total < mkte_pkg::PressWrap)
    else $error("press counter left the decimal range");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    line_len <= FullLen)
    else $error("line length beyond line capacity");
`endif

endmodule

`default_nettype wire

>>> src/multitap_keypad_text_entry.sv
// Multi-tap keypad text entry: key decoder, a row of character cells, and an output shift chain.
// An accepted key transaction updates the cell characters; the next snapshot loads them into the output slots.
// The output chain moves one column per cycle while the sink is ready; the next key transaction is
//   taken while a run drains and is snapshot as the last column of that run leaves.
// Reset: line all spaces, length zero, letter mode, no taps, press count zero, no output.
`timescale 1ns / 1ps
`default_nettype none

module multitap_keypad_text_entry #(
  parameter int LINE_LENGTH = mkte_pkg::LineLengthDefault
) (
  input  wire logic   clk,
  input  wire logic   rst,
  mkte_in_if.sink     in_ch,
  mkte_out_if.source  out_ch
);

  // Column index width and a length width that can hold LINE_LENGTH itself
  localparam int IDX_W = (LINE_LENGTH > 1) ? $clog2(LINE_LENGTH) : 1;
  localparam int LEN_W = $clog2(LINE_LENGTH + 1);
  localparam logic [LEN_W-1:0] RunLen  = LEN_W'(LINE_LENGTH);
  localparam logic [4:0]       PosLast = 5'((LINE_LENGTH - 1) % 32);

  mkte_pkg::line_op_t          op;
  mkte_pkg::out_op_t           out_op;
  logic [IDX_W-1:0]            wr_idx;
  logic [LEN_W-1:0]            line_len;
  logic                        mode;
  logic [mkte_pkg::PressW-1:0] press_total;

  logic [7:0]                  cell_ch  [LINE_LENGTH];
  logic [7:0]                  cell_out [LINE_LENGTH];

  // Output run bookkeeping
  logic                        pend;      // line updated, snapshot not yet taken
  logic [LEN_W-1:0]            rem;       // columns of the current run still to deliver
  logic [4:0]                  pos;
  logic                        mode_q;
  logic [mkte_pkg::PressW-1:0] press_q;
  logic                        in_fire;
  logic                        out_fire;

  // Take a key transaction whenever the previous update has been snapshot
  assign in_ch.ready = !pend;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  // Snapshot the line once the chain is empty or its last column leaves in this cycle
  assign out_op.load    = pend && (rem == '0 || (rem == LEN_W'(1) && out_fire));
  assign out_op.advance = out_fire && !out_op.load;

  mkte_ctrl #(
    .LINE_LENGTH (LINE_LENGTH),
    .IDX_W       (IDX_W),
    .LEN_W       (LEN_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .fire        (in_fire),
    .keys        (in_ch.keys_pressed),
    .op          (op),
    .wr_idx      (wr_idx),
    .line_len    (line_len),
    .mode        (mode),
    .press_total (press_total)
  );

  // Row of columns: each hands its character left on a shift and its output slot left on
  // each delivered transaction that takes no snapshot; the last column takes the new character / a space.
  for (genvar i = 0; i < LINE_LENGTH; i++) begin : g_cell
    logic [7:0] right_ch;
    logic [7:0] right_out;
    logic       wr_en;
    logic       visible;

    if (i == LINE_LENGTH - 1) begin : g_edge
      assign right_ch  = op.ch;
      assign right_out = mkte_pkg::SpaceCode;
    end else begin : g_inner
      assign right_ch  = cell_ch[i + 1];
      assign right_out = cell_out[i + 1];
    end

    assign wr_en   = op.write && (wr_idx == IDX_W'(i));
    assign visible = LEN_W'(i) < line_len;

    mkte_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (op),
      .wr_en     (wr_en),
      .right_ch  (right_ch),
      .visible   (visible),
      .out_op    (out_op),
      .right_out (right_out),
      .ch        (cell_ch[i]),
      .out_ch    (cell_out[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      rem  <= '0;
      pos  <= '0;
    end else begin
      if (in_fire) begin
        pend <= 1'b1;
      end else if (out_op.load) begin
        pend <= 1'b0;
      end
      if (out_op.load) begin
        rem <= RunLen;
        pos <= '0;
      end else if (out_fire) begin
        rem <= rem - LEN_W'(1);
        pos <= pos + 5'd1;
      end
    end
  end

  // Mode and press count hold for the whole run
  always_ff @(posedge clk) begin
    if (out_op.load) begin
      mode_q  <= mode;
      press_q <= press_total;
    end
  end

  assign out_ch.valid         = rem != '0;
  assign out_ch.char_position = pos;
  assign out_ch.char_code     = cell_out[0];
  assign out_ch.digit_mode    = mode_q;
  assign out_ch.press_count   = press_q;
  assign out_ch.last_char     = rem == LEN_W'(1);

`ifndef NO_ASSERTIONS
  a_fire_pends: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> pend)
    else $error("accepted key transaction not marked for snapshot");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.last_char |-> pos == PosLast)
    else $error("run ends at the wrong column");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    out_op.load |=> out_ch.valid && pos == 5'd0 && !out_ch.last_char || RunLen == LEN_W'(1))
    else $error("snapshot did not start a run at column zero");

  a_drain_idle: assert property (@(posedge clk) disable iff (rst)
    out_fire && out_ch.last_char && !pend |=> !out_ch.valid)
    else $error("output stayed valid after the last column");
`endif

endmodule

`default_nettype wire
